/* sv/coalescing_command_queue_top_assert.svh */
// Assertion macros for the coalescing command queue.
`ifndef COALESCING_COMMAND_QUEUE_TOP_ASSERT_SVH
`define COALESCING_COMMAND_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTH
`define CCQ_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CCQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CCQ_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define CCQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/ccq_pkg.sv */
// Shared types and constants of the coalescing command queue.
package ccq_pkg;
    localparam int QueueLimit = 16;
    localparam int Capacity   = 32;
    localparam int CodeCount  = 16;
    localparam int AddrW      = $clog2(Capacity);
    localparam int CountW     = $clog2(Capacity + 1);

    typedef enum logic [1:0] {
        CMD_POST    = 2'd0,
        CMD_TAKE    = 2'd1,
        CMD_REQUEUE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    localparam logic CFG_OBSOLETE  = 1'b0;
    localparam logic CFG_EXCLUSIVE = 1'b1;

    typedef struct packed {
        logic        wr_en;
        logic [AddrW-1:0] wr_addr;
        logic [3:0]  wr_code;
        logic [31:0] wr_payload;
        logic [AddrW-1:0] rd_addr;
    } mem_req_t;

    function automatic logic mask_has(logic [15:0] mask, logic [3:0] c);
        mask_has = (32'(c) < CodeCount) && mask[c];
    endfunction
endpackage

/* sv/ccq_mem.sv */
// Entry storage: one write port, one registered read port.
module ccq_mem import ccq_pkg::*; (
    input  logic        aclk,
    input  mem_req_t    req,
    output logic [3:0]  rd_code,
    output logic [31:0] rd_payload
);
    logic [35:0] mem_reg [Capacity];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= {req.wr_code, req.wr_payload};
        end
        {rd_code, rd_payload} <= mem_reg[req.rd_addr];
    end
endmodule

/* sv/ccq_ctrl.sv */
// Sequencer: scans and compacts the queue one entry per cycle.
`include "coalescing_command_queue_top_assert.svh"
module ccq_ctrl import ccq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_go,
    input  logic [1:0]  in_cmd,
    input  logic [3:0]  in_code,
    input  logic [31:0] in_payload,
    input  logic [15:0] in_sup,
    input  logic [3:0]  obsolete_above,
    input  logic [15:0] exclusive_mask,
    output logic        busy,
    output mem_req_t    mreq,
    input  logic [3:0]  rd_code,
    input  logic [31:0] rd_payload,
    output logic        res_valid,
    output logic [44:0] res_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_TAIL = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next, live_reg, live_next;
    logic [CountW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic              pend_reg, pend_next;
    logic [1:0]  cmd_reg;
    logic [3:0]  code_reg;
    logic [31:0] pay_reg;
    logic [15:0] sup_reg;
    logic        excl_reg, found_reg, found_next, rej_reg, rej_next;
    logic [3:0]  tcode_reg, tcode_next;
    logic [31:0] tpay_reg, tpay_next;
    logic        drop;

    assign busy = (state_reg != ST_IDLE);

    // pend_reg: read of entry rd_reg-1 issued last cycle, data on rd_code now.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        live_next  = live_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        pend_next  = 1'b0;
        found_next = found_reg;
        rej_next   = rej_reg;
        tcode_next = tcode_reg;
        tpay_next  = tpay_reg;
        mreq       = '0;
        mreq.rd_addr = rd_reg[AddrW-1:0];
        drop       = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_go) begin
                    rd_next    = '0;
                    wr_next    = '0;
                    live_next  = count_reg;
                    found_next = 1'b0;
                    rej_next   = 1'b0;
                    tcode_next = '0;
                    tpay_next  = '0;
                    unique case (cmd_t'(in_cmd)) inside
                        CMD_POST, CMD_TAKE: state_next = ST_SCAN;
                        CMD_REQUEUE: state_next = ST_TAIL;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (cmd_reg == CMD_POST) begin
                        drop = ((rd_code > obsolete_above) && (32'(live_reg) > QueueLimit))
                            || (excl_reg && rd_code == code_reg);
                    end else begin
                        drop = !found_reg && mask_has(sup_reg, rd_code);
                    end
                    if (drop) begin
                        live_next = live_reg - 1'b1;
                        if (cmd_reg == CMD_TAKE) begin
                            found_next = 1'b1;
                            tcode_next = rd_code;
                            tpay_next  = rd_payload;
                        end
                    end else begin
                        mreq.wr_en      = 1'b1;
                        mreq.wr_addr    = wr_reg[AddrW-1:0];
                        mreq.wr_code    = rd_code;
                        mreq.wr_payload = rd_payload;
                        wr_next = wr_reg + 1'b1;
                    end
                end
                if (rd_reg < count_reg) begin
                    rd_next   = rd_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    count_next = wr_reg;
                    state_next = (cmd_reg == CMD_POST) ? ST_TAIL : ST_DONE;
                end
            end
            ST_TAIL: begin
                if (32'(count_reg) >= Capacity) begin
                    rej_next = 1'b1;
                end else begin
                    mreq.wr_en      = 1'b1;
                    mreq.wr_addr    = count_reg[AddrW-1:0];
                    mreq.wr_code    = code_reg;
                    mreq.wr_payload = pay_reg;
                    count_next      = count_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res_data = {6'(count_reg), rej_reg, (32'(count_reg) > QueueLimit),
                       tpay_reg, tcode_reg, found_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        live_reg  <= live_next;
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        found_reg <= found_next;
        rej_reg   <= rej_next;
        tcode_reg <= tcode_next;
        tpay_reg  <= tpay_next;
        if (in_go && state_reg == ST_IDLE) begin
            cmd_reg  <= in_cmd;
            code_reg <= in_code;
            pay_reg  <= in_payload;
            sup_reg  <= in_sup;
            excl_reg <= mask_has(exclusive_mask, in_code);
        end
    end

    `CCQ_ASSERT_IMPL(a_count_cap, aclk, aresetn, 32'(count_reg) <= Capacity,
        "count above capacity")
    `CCQ_ASSERT_IMPL(a_wr_le_rd, aclk, aresetn, !(state_reg == ST_SCAN) || wr_reg <= rd_reg,
        "compaction write passed read")
    `CCQ_ASSERT_NEXT(a_done_idle, aclk, aresetn, state_reg == ST_DONE,
        state_reg == ST_IDLE, "done not followed by idle")
endmodule

/* sv/coalescing_command_queue_top.sv */
// Top level of the coalescing command queue.
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | command, code, payload, supported_mask
//  m_      | out | m_tvalid/m_tready  | found..occupancy
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// From accept to m_tvalid: post and take scan the queue, one memory read and
// compaction write per entry, then post appends; requeue only appends.
// The single-port-write entry memory sets the pace. Reset is synchronous and
// empties the queue. A result waits in an output register; the next item is
// accepted in the cycle after the result is taken.
`include "coalescing_command_queue_top_assert.svh"
module coalescing_command_queue_top import ccq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // command[1:0], code[5:2], payload[37:6], supported_mask[53:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // found[0], taken_code[4:1], taken_payload[36:5],
                                  // overfull[37], rejected[38], occupancy[44:39]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    logic [3:0]  obs_reg;
    logic [15:0] excl_reg;
    logic        busy, res_valid, out_valid_reg;
    logic [44:0] res_data;
    logic [44:0] out_reg;
    mem_req_t    mreq;
    logic [3:0]  rd_code;
    logic [31:0] rd_payload;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b0, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_reg       <= 4'd7;
            excl_reg      <= 16'd1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_OBSOLETE:  obs_reg  <= cfg_data[3:0];
                    CFG_EXCLUSIVE: excl_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (res_valid) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
        if (res_valid) out_reg <= res_data;
    end

    ccq_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_go(s_tvalid && s_tready),
        .in_cmd(s_tdata[1:0]), .in_code(s_tdata[5:2]),
        .in_payload(s_tdata[37:6]), .in_sup(s_tdata[53:38]),
        .obsolete_above(obs_reg), .exclusive_mask(excl_reg),
        .busy, .mreq, .rd_code, .rd_payload, .res_valid, .res_data
    );

    ccq_mem u_mem (.aclk, .req(mreq), .rd_code, .rd_payload);

    `CCQ_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
        "result dropped")
    `CCQ_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, !(s_tready && busy),
        "accept while busy")
    `CCQ_ASSERT_IMPL(a_res_free, aclk, aresetn, !(res_valid && out_valid_reg),
        "result over pending output")
endmodule

/* tb/sv/coalescing_command_queue_top_tb.sv */
// Self-checking testbench for the coalescing command queue: directed table, then random traffic.
module coalescing_command_queue_top_tb;
    import ccq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit   = 20000;
    localparam int RandomItems = 1830;

    typedef struct {
        logic        found;
        logic [3:0]  taken_code;
        logic [31:0] taken_payload;
        logic        overfull;
        logic        rejected;
        logic [5:0]  occupancy;
    } queue_result_t;

    typedef struct {
        cmd_t        cmd;
        logic [3:0]  code;
        logic [31:0] payload;
        logic [15:0] supported;
        bit          has_expect;
        logic        exp_found;
        logic        exp_rejected;
        logic [5:0]  exp_occupancy;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_OBSOLETE;
    logic [15:0] cfg_data = '0;

    always #5 aclk = ~aclk;

    coalescing_command_queue_top i_dut (.*);

    // Predictor state
    logic [3:0]  model_codes[Capacity];
    logic [31:0] model_payloads[Capacity];
    int          model_count;
    logic [3:0]  model_obsolete;
    logic [15:0] model_exclusive;

    queue_result_t expected_results[$];
    int  error_count;
    int  result_count;
    int  idle_cycles;
    bit  quiet_tail;
    int  hold_off_cycles;
    bit  hold_done;
    int  post_count, take_hits, reject_count;

    function automatic logic code_in_mask(logic [15:0] mask, logic [3:0] c);
        return (int'(c) < CodeCount) ? mask[c] : 1'b0;
    endfunction

    function automatic queue_result_t predict_queue(cmd_t cmd, logic [3:0] code,
                                                    logic [31:0] payload,
                                                    logic [15:0] supported);
        queue_result_t r;
        int live, w;
        logic excl;
        r = '{default: '0};
        case (cmd)
            CMD_POST: begin
                excl = code_in_mask(model_exclusive, code);
                live = model_count;
                w = 0;
                for (int i = 0; i < model_count; i++) begin
                    if ((model_codes[i] > model_obsolete && live > QueueLimit) ||
                        (excl && model_codes[i] == code)) begin
                        live--;
                    end else begin
                        model_codes[w] = model_codes[i];
                        model_payloads[w] = model_payloads[i];
                        w++;
                    end
                end
                model_count = w;
                if (model_count >= Capacity) begin
                    r.rejected = 1'b1;
                end else begin
                    model_codes[model_count] = code;
                    model_payloads[model_count] = payload;
                    model_count++;
                end
            end
            CMD_TAKE: begin
                for (int i = 0; i < model_count; i++) begin
                    if (code_in_mask(supported, model_codes[i])) begin
                        r.found = 1'b1;
                        r.taken_code = model_codes[i];
                        r.taken_payload = model_payloads[i];
                        for (int j = i; j + 1 < model_count; j++) begin
                            model_codes[j] = model_codes[j + 1];
                            model_payloads[j] = model_payloads[j + 1];
                        end
                        model_count--;
                        break;
                    end
                end
            end
            CMD_REQUEUE: begin
                if (model_count >= Capacity) begin
                    r.rejected = 1'b1;
                end else begin
                    model_codes[model_count] = code;
                    model_payloads[model_count] = payload;
                    model_count++;
                end
            end
            default: ;
        endcase
        r.overfull = model_count > QueueLimit;
        r.occupancy = 6'(model_count);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("ERROR: result %0d field %s got 0x%0h expected 0x%0h at %0t",
                 result_count, field, got, want, $realtime);
    endtask

    // Send one command and queue its expectation at the handshake.
    task automatic send_command(cmd_t cmd, logic [3:0] code, logic [31:0] payload,
                                logic [15:0] supported);
        queue_result_t r;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, supported, payload, code, cmd};
        do @(posedge aclk); while (!s_tready);
        r = predict_queue(cmd, code, payload, supported);
        expected_results = {expected_results, r};
        if (cmd == CMD_POST) post_count++;
        if (r.found) take_hits++;
        if (r.rejected) reject_count++;
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_queue();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OBSOLETE) model_obsolete = value[3:0];
        else model_exclusive = value;
        @(posedge aclk);
    endtask

    task automatic random_command(int post_weight);
        int pick;
        logic [3:0] c;
        pick = $urandom_range(0, 99);
        c = $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
        if (pick < post_weight)
            send_command(CMD_POST, c, $urandom, 16'($urandom));
        else if (pick < post_weight + 25)
            send_command(CMD_TAKE, c, $urandom,
                         $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
        else if (pick < 97)
            send_command(CMD_REQUEUE, c, $urandom, 16'($urandom));
        else
            send_command(CMD_NONE, c, $urandom, 16'($urandom));
    endtask

    // Receiver: random stalls, one long hold-off, compare against oldest expectation.
    initial begin
        queue_result_t want;
        @(posedge aresetn);
        forever begin
            if (!hold_done && post_count > 300) begin
                m_tready <= 1'b0;
                hold_done = 1'b1;
                for (hold_off_cycles = 0; hold_off_cycles < 400; hold_off_cycles++)
                    @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected", m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.found)
                        report_mismatch("found", m_tdata[0], want.found);
                    if (m_tdata[4:1] !== want.taken_code)
                        report_mismatch("taken_code", m_tdata[4:1], want.taken_code);
                    if (m_tdata[36:5] !== want.taken_payload)
                        report_mismatch("taken_payload", m_tdata[36:5], want.taken_payload);
                    if (m_tdata[37] !== want.overfull)
                        report_mismatch("overfull", m_tdata[37], want.overfull);
                    if (m_tdata[38] !== want.rejected)
                        report_mismatch("rejected", m_tdata[38], want.rejected);
                    if (m_tdata[44:39] !== want.occupancy)
                        report_mismatch("occupancy", m_tdata[44:39], want.occupancy);
                end
                result_count++;
            end
        end
    end

    // Watchdog: count cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Timeout: no transaction for %0d cycles", IdleLimit);
            $display("Simulation FAILED");
            $finish;
        end
    end

    stim_row_t directed[] = '{
        '{CMD_TAKE,    4'd0,  32'h0,         16'hFFFF, 1, 1'b0, 1'b0, 6'd0},
        '{CMD_NONE,    4'd15, 32'hFFFFFFFF,  16'hFFFF, 1, 1'b0, 1'b0, 6'd0},
        '{CMD_POST,    4'd0,  32'hFFFFFFFF,  16'h0,    1, 1'b0, 1'b0, 6'd1},
        '{CMD_POST,    4'd0,  32'h12345678,  16'h0,    1, 1'b0, 1'b0, 6'd1},
        '{CMD_POST,    4'd15, 32'h0,         16'h0,    1, 1'b0, 1'b0, 6'd2},
        '{CMD_REQUEUE, 4'd0,  32'hA5A5A5A5,  16'h0,    1, 1'b0, 1'b0, 6'd3},
        '{CMD_TAKE,    4'd0,  32'h0,         16'h0,    1, 1'b0, 1'b0, 6'd3},
        '{CMD_TAKE,    4'd0,  32'h0,         16'h8000, 0, 1'b0, 1'b0, 6'd0},
        '{CMD_TAKE,    4'd0,  32'h0,         16'h0001, 0, 1'b0, 1'b0, 6'd0},
        '{CMD_REQUEUE, 4'd9,  32'h5A5A5A5A,  16'h0,    0, 1'b0, 1'b0, 6'd0},
        '{CMD_POST,    4'd9,  32'h0F0F0F0F,  16'h0,    0, 1'b0, 1'b0, 6'd0},
        '{CMD_TAKE,    4'd0,  32'h0,         16'hFFFF, 0, 1'b0, 1'b0, 6'd0},
        '{CMD_TAKE,    4'd0,  32'h0,         16'hFFFF, 0, 1'b0, 1'b0, 6'd0},
        '{CMD_TAKE,    4'd0,  32'h0,         16'hFFFF, 0, 1'b0, 1'b0, 6'd0},
        '{CMD_TAKE,    4'd0,  32'h0,         16'hFFFF, 1, 1'b0, 1'b0, 6'd0}
    };

    initial begin
        queue_result_t r;
        error_count = 0; result_count = 0; idle_cycles = 0;
        quiet_tail = 0; hold_done = 0;
        post_count = 0; take_hits = 0; reject_count = 0;
        model_count = 0;
        model_obsolete = 4'd7;
        model_exclusive = 16'h0001;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[k]) begin
            send_command(directed[k].cmd, directed[k].code, directed[k].payload,
                         directed[k].supported);
            r = expected_results[$];
            if (directed[k].has_expect && (r.found !== directed[k].exp_found ||
                r.occupancy !== directed[k].exp_occupancy ||
                r.rejected !== directed[k].exp_rejected))
                report_mismatch("directed row", k, r.occupancy);
        end
        drain_queue();

        // Fill past capacity with requeues, then post into a full store.
        repeat (34) send_command(CMD_REQUEUE, 4'd3, $urandom, 16'h0);
        send_command(CMD_POST, 4'd2, 32'hDEADBEEF, 16'h0);
        drain_queue();
        write_register(CFG_OBSOLETE, 16'd15);
        send_command(CMD_POST, 4'd1, 32'hCAFEF00D, 16'h0);
        drain_queue();
        write_register(CFG_EXCLUSIVE, 16'h0008);
        send_command(CMD_POST, 4'd3, 32'h11111111, 16'h0);
        drain_queue();

        // Random phases across register settings; the sender pauses at each boundary.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_register(CFG_OBSOLETE, 16'd0);
                         write_register(CFG_EXCLUSIVE, 16'hFFFF); end
                1: begin write_register(CFG_OBSOLETE, 16'd15);
                         write_register(CFG_EXCLUSIVE, 16'h0000); end
                default: begin write_register(CFG_OBSOLETE, 16'($urandom_range(0, 15)));
                         write_register(CFG_EXCLUSIVE, 16'($urandom)); end
            endcase
            if (phase == 5) quiet_tail = 1;
            repeat (RandomItems / 6) random_command(phase == 1 ? 60 : 45);
            drain_queue();
        end

        $display("Covered %0d results: %0d posts, %0d takes that found an entry, %0d rejects,",
                 result_count, post_count, take_hits, reject_count);
        $display("register sweeps over obsolete threshold and exclusive mask extremes.");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
